// ----- hw/rtl/tlvrf_pkg.sv -----
// Shared types and codes for the TLV record finder.
// No dependencies; imported by the scanner, the top level and the checker.
`timescale 1ns / 1ps

package tlvrf_pkg;

    // Default for the largest payload a message may carry.
    localparam int MAX_PAYLOAD_BYTES_DEFAULT = 65535;

    // Configuration register indexes.
    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] REG_WANTED_TYPE     = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_END_MARKER_TYPE = 1'd1;

    // Result outcome codes.
    localparam logic [1:0] OUTCOME_FOUND  = 2'd0;
    localparam logic [1:0] OUTCOME_ABSENT = 2'd1;
    localparam logic [1:0] OUTCOME_FAULT  = 2'd2;

    // Scan phases.
    localparam logic [1:0] PH_TYPE = 2'd0;
    localparam logic [1:0] PH_LEN  = 2'd1;
    localparam logic [1:0] PH_SKIP = 2'd2;

    // Decision codes held while a message is scanned.
    localparam logic [1:0] DEC_NONE   = 2'd0;
    localparam logic [1:0] DEC_FOUND  = 2'd1;
    localparam logic [1:0] DEC_ABSENT = 2'd2;
    localparam logic [1:0] DEC_FAULT  = 2'd3;

    typedef struct packed {
        logic [1:0]  outcome;
        logic [15:0] value_length;
        logic [15:0] value_offset;
    } result_t;

endpackage

// ----- hw/rtl/tlvrf_scanner.sv -----
// Record scanner: per-message parse state and the result of the final byte.
// Depends on tlvrf_pkg.
`timescale 1ns / 1ps

module tlvrf_scanner
    import tlvrf_pkg::*;
#(
    parameter int MAX_PAYLOAD_BYTES = MAX_PAYLOAD_BYTES_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        step,
    input  logic [7:0]  in_byte,
    input  logic        in_last,
    input  logic [31:0] wanted_type,
    input  logic [31:0] end_marker_type,
    output result_t     result
);

    // Counter holds up to MAX_PAYLOAD_BYTES + 1 (saturation point).
    localparam int CW = $clog2(MAX_PAYLOAD_BYTES + 2);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_PAYLOAD_BYTES);

    logic [1:0]    phase_reg,   phase_next;
    logic [1:0]    idx_reg,     idx_next;
    logic [23:0]   word_reg,    word_next;
    logic [CW-1:0] seen_reg,    seen_next;
    logic [CW-1:0] skip_reg,    skip_next;
    logic [1:0]    dec_reg,     dec_next;
    logic [CW-1:0] mlen_reg,    mlen_next;
    logic [CW-1:0] moff_reg,    moff_next;
    logic [CW:0]   mend_reg,    mend_next;
    logic          matched_reg, matched_next;

    logic [31:0]   word_full;
    logic [CW-1:0] skip_dec;
    logic [CW-1:0] len_cut;

    assign word_full = {word_reg, in_byte};
    assign len_cut   = word_full[CW-1:0];
    assign skip_dec  = (skip_reg != '0) ? skip_reg - 1'b1 : skip_reg;

    always_comb begin
        phase_next   = phase_reg;
        idx_next     = idx_reg;
        word_next    = word_reg;
        skip_next    = skip_reg;
        dec_next     = dec_reg;
        mlen_next    = mlen_reg;
        moff_next    = moff_reg;
        mend_next    = mend_reg;
        matched_next = matched_reg;
        seen_next    = (seen_reg <= MAX_CNT) ? seen_reg + 1'b1 : seen_reg;

        if (seen_next > MAX_CNT) begin
            dec_next = DEC_FAULT;
        end else if (dec_reg == DEC_NONE) begin
            unique case (phase_reg)
                PH_SKIP: begin
                    skip_next = skip_dec;
                    if (skip_dec == '0) begin
                        phase_next = PH_TYPE;
                    end
                end
                PH_TYPE: begin
                    word_next = word_full[23:0];
                    idx_next  = idx_reg + 2'd1;
                    if (idx_reg == 2'd3) begin
                        if (word_full == end_marker_type) begin
                            dec_next = DEC_ABSENT;
                        end else begin
                            matched_next = (word_full == wanted_type);
                            phase_next   = PH_LEN;
                        end
                    end
                end
                PH_LEN: begin
                    word_next = word_full[23:0];
                    idx_next  = idx_reg + 2'd1;
                    if (idx_reg == 2'd3) begin
                        if (word_full[31] || word_full > 32'(MAX_PAYLOAD_BYTES)) begin
                            dec_next = DEC_FAULT;
                        end else if (matched_reg) begin
                            dec_next  = DEC_FOUND;
                            mlen_next = len_cut;
                            moff_next = seen_next;
                            mend_next = {1'b0, seen_next} + {1'b0, len_cut};
                        end else if (word_full == 32'd0) begin
                            phase_next = PH_TYPE;
                        end else begin
                            skip_next  = len_cut;
                            phase_next = PH_SKIP;
                        end
                    end
                end
                default: begin
                    phase_next = PH_TYPE;
                end
            endcase
        end
    end

    // Outcome of the message, valid when the final byte is stepped.
    always_comb begin
        result = '0;
        if (dec_next == DEC_FOUND && {1'b0, seen_next} >= mend_next) begin
            result.outcome      = OUTCOME_FOUND;
            result.value_length = 16'(mlen_next);
            result.value_offset = 16'(moff_next);
        end else if (dec_next == DEC_ABSENT) begin
            result.outcome = OUTCOME_ABSENT;
        end else begin
            result.outcome = OUTCOME_FAULT;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (step && in_last)) begin
            phase_reg   <= PH_TYPE;
            idx_reg     <= 2'd0;
            word_reg    <= '0;
            seen_reg    <= '0;
            skip_reg    <= '0;
            dec_reg     <= DEC_NONE;
            mlen_reg    <= '0;
            moff_reg    <= '0;
            mend_reg    <= '0;
            matched_reg <= 1'b0;
        end else if (step) begin
            phase_reg   <= phase_next;
            idx_reg     <= idx_next;
            word_reg    <= word_next;
            seen_reg    <= seen_next;
            skip_reg    <= skip_next;
            dec_reg     <= dec_next;
            mlen_reg    <= mlen_next;
            moff_reg    <= moff_next;
            mend_reg    <= mend_next;
            matched_reg <= matched_next;
        end
    end

endmodule

// ----- hw/rtl/tlv_record_finder_core.sv -----
// Top level of the TLV record finder: input register, scanner, result register
// and configuration registers. Depends on tlvrf_pkg and tlvrf_scanner.
`timescale 1ns / 1ps

// Usage
// The s_ channel carries one payload byte per request in s_tdata, with s_tlast
// high on the final byte of a message. The payload is a list of records, each a
// big-endian 32-bit type, a big-endian 32-bit length and the value bytes. The
// block searches for the first record whose type equals wanted_type and stops
// at end_marker_type. For each request with s_tlast high the m_ channel
// delivers exactly one result request; other bytes produce no result.
// Throughput is one byte per cycle while no final byte waits on a stalled
// result: each byte needs a counter step, a word shift and a 32-bit compare in
// the scanner, done between the input register and the result register.
// m_tvalid rises as the result register loads the outcome of a final byte held
// in the input register; the scanner adds no register stage. When the receiver
// stalls with a result waiting, the block still accepts non-final bytes of the
// next message; a further final byte is held in the input register until the
// pending result is taken, and s_tready drops only then. A synchronous
// active-low reset clears the parse state, empties both registers and sets both
// configuration registers to zero. The user must write configuration (cfg_wr_en,
// cfg_wr_index, cfg_wr_data) only while the block idles; the block does not enforce this.

module tlv_record_finder_core
    import tlvrf_pkg::*;
#(
    parameter int MAX_PAYLOAD_BYTES = MAX_PAYLOAD_BYTES_DEFAULT
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // Input requests.
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [7:0]             s_tdata,      // [7:0] payload_byte
    input  logic                   s_tlast,      // last_byte
    // Result requests.
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [31:0]            m_tdata,      // [15:0] value_length, [31:16] value_offset
    output logic [1:0]             m_tuser,      // [1:0] outcome
    // Configuration writes.
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_wr_index,
    input  logic [31:0]            cfg_wr_data
);

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_last_reg;
    logic        m_valid_reg;
    result_t     m_result_reg;
    logic [31:0] wanted_type_reg;
    logic [31:0] end_marker_reg;

    logic        out_free;
    logic        advance;
    logic        s_accept;
    result_t     scan_result;

    // A held byte moves on unless it is a final byte and the result slot is full.
    assign out_free = !m_valid_reg || m_tready;
    assign advance  = in_valid_reg && (!in_last_reg || out_free);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_accept) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    tlvrf_scanner #(
        .MAX_PAYLOAD_BYTES(MAX_PAYLOAD_BYTES)
    ) u_scanner (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .step            (advance),
        .in_byte         (in_byte_reg),
        .in_last         (in_last_reg),
        .wanted_type     (wanted_type_reg),
        .end_marker_type (end_marker_reg),
        .result          (scan_result)
    );

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance && in_last_reg) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_last_reg) begin
            m_result_reg <= scan_result;
        end
    end

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wanted_type_reg <= '0;
            end_marker_reg  <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                REG_WANTED_TYPE:     wanted_type_reg <= cfg_wr_data;
                REG_END_MARKER_TYPE: end_marker_reg  <= cfg_wr_data;
                default: begin
                end
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_result_reg.value_offset, m_result_reg.value_length};
    assign m_tuser  = m_result_reg.outcome;

endmodule

// ----- hw/rtl/tlvrf_checker.sv -----
// Port-level checker for the TLV record finder, bound to the top level.
// Depends on tlvrf_pkg and tlv_record_finder_core.
`timescale 1ns / 1ps

module tlvrf_checker
    import tlvrf_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [1:0]  m_tuser
);

    // Reset empties the result register.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // A stalled result holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // Only the three defined outcomes are produced.
    a_outcome: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == OUTCOME_FOUND || m_tuser == OUTCOME_ABSENT ||
                      m_tuser == OUTCOME_FAULT))
        else $error("undefined outcome");

    // Absent and fault results carry zero length and offset.
    a_zero_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != OUTCOME_FOUND |-> m_tdata == 32'd0)
        else $error("non-found result carries data");

endmodule

bind tlv_record_finder_core tlvrf_checker u_tlvrf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
